### rtl/stc_pkg.sv
`default_nettype none

package stc_pkg;

  localparam int TapsDefault = 32;
  localparam int CoeffIdxW   = 6;
  localparam int TapW        = 16;
  localparam int SumW        = 22;

  localparam logic ReqSpike = 1'b0;
  localparam logic ReqLoad  = 1'b1;

  typedef struct packed {
    logic shift;
    logic load;
    logic advance;
  } cell_ctl_t;

endpackage

`default_nettype wire

### rtl/stc_cell.sv
`default_nettype none

module stc_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  stc_pkg::cell_ctl_t                  ctl_i,
  input  logic                                hist_i,
  input  logic signed [stc_pkg::TapW-1:0]     tap_i,
  input  logic signed [stc_pkg::SumW-1:0]     sum_i,
  input  logic                                valid_i,
  output logic                                hist_o,
  output logic signed [stc_pkg::SumW-1:0]     sum_o,
  output logic                                valid_o
);
  import stc_pkg::*;

  logic                   hist_q;
  logic signed [TapW-1:0] tap_q;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic                   valid_q;

  // add this tap when its spike is set
  assign sum_d = sum_i + (hist_q ? SumW'(tap_q) : SumW'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= 1'b0;
      tap_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (ctl_i.shift) begin
        hist_q <= hist_i;
      end
      if (ctl_i.load) begin
        tap_q <= tap_i;
      end
      if (ctl_i.advance) begin
        valid_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      sum_q <= sum_d;
    end
  end

  assign hist_o  = hist_q;
  assign sum_o   = sum_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

### rtl/spike_train_kernel_convolver.sv
// Path: a spike transfer sets start_q, then its partial sum walks the chain of
// tap cells one cell per cycle while the chain is not held; the output register
// takes it from the last cell. No new item is taken while a sum is in flight.
// A waiting result does not block the chain until the next sum reaches its end.
// Reset clears the spike history, all taps and every valid flag at once.
`default_nettype none

module spike_train_kernel_convolver #(
  parameter int Taps = stc_pkg::TapsDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 req_type_i,
  input  logic                                 spike_i,
  input  logic                                 start_of_train_i,
  input  logic                                 end_of_train_i,
  input  logic [stc_pkg::CoeffIdxW-1:0]        coeff_index_i,
  input  logic signed [stc_pkg::TapW-1:0]      coeff_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [stc_pkg::SumW-1:0]      filtered_value_o,
  output logic                                 last_of_train_o
);
  import stc_pkg::*;

  logic                   in_xfer, spike_xfer, load_xfer, advance;
  logic                   start_q, last_q;
  logic                   out_valid_q, out_last_q;
  logic signed [SumW-1:0] out_value_q;

  logic                   hist  [Taps];
  logic                   hist_in [Taps];
  logic signed [SumW-1:0] sum   [Taps];
  logic signed [SumW-1:0] sum_in [Taps];
  logic [Taps-1:0]        valid;
  logic [Taps-1:0]        valid_in;
  cell_ctl_t              ctl   [Taps];

  assign in_stall_o = start_q | (|valid);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign spike_xfer = in_xfer & (req_type_i == ReqSpike);
  assign load_xfer  = in_xfer & (req_type_i == ReqLoad);

  // hold the chain only when its result cannot move to the output register
  assign advance = ~(valid[Taps-1] & out_valid_q & out_stall_i);

  for (genvar k = 0; k < Taps; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign hist_in[k]  = spike_i;
      assign sum_in[k]   = '0;
      assign valid_in[k] = start_q;
    end else begin : g_body
      // start of train drops the old history
      assign hist_in[k]  = start_of_train_i ? 1'b0 : hist[k-1];
      assign sum_in[k]   = sum[k-1];
      assign valid_in[k] = valid[k-1];
    end

    assign ctl[k].shift   = spike_xfer;
    assign ctl[k].load    = load_xfer & (coeff_index_i == CoeffIdxW'(k));
    assign ctl[k].advance = advance;

    stc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[k]),
      .hist_i  (hist_in[k]),
      .tap_i   (coeff_value_i),
      .sum_i   (sum_in[k]),
      .valid_i (valid_in[k]),
      .hist_o  (hist[k]),
      .sum_o   (sum[k]),
      .valid_o (valid[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (spike_xfer) begin
        start_q <= 1'b1;
      end else if (advance) begin
        start_q <= 1'b0;
      end
      if (valid[Taps-1] && advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (spike_xfer) begin
      last_q <= end_of_train_i;
    end
    if (valid[Taps-1] && advance) begin
      out_value_q <= sum[Taps-1];
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign last_of_train_o  = out_last_q;

  a_one_wave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({start_q, valid}))
    else $error("more than one sum in flight");

  a_wave_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> valid[0])
    else $error("sum did not enter the first cell");

  a_spike_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spike_xfer |=> in_stall_o)
    else $error("input open while a sum is pending");

  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid[Taps-1] && advance) |=> out_valid_q)
    else $error("finished sum not captured");

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
  import stc_pkg::*;

  localparam int Taps          = TapsDefault;
  localparam int TapIdxW       = $clog2(Taps);
  localparam int RandomItems   = 1900;
  localparam int CalmItems     = 150;
  localparam int WatchdogLimit = 2000;
  localparam int DirRows       = 12;
  localparam int MaxPrinted    = 40;

  typedef struct packed {
    logic                   req;
    logic                   spike;
    logic                   sot;
    logic                   eot;
    logic [CoeffIdxW-1:0]   idx;
    logic signed [TapW-1:0] val;
    logic                   has_want;
    logic signed [SumW-1:0] want_value;
    logic                   want_last;
  } stim_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] value;
    logic                   last;
  } conv_result_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   req_type_i;
  logic                   spike_i;
  logic                   start_of_train_i;
  logic                   end_of_train_i;
  logic [CoeffIdxW-1:0]   coeff_index_i;
  logic signed [TapW-1:0] coeff_value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [SumW-1:0] filtered_value_o;
  logic                   last_of_train_o;

  spike_train_kernel_convolver #(
    .Taps(Taps)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .spike_i          (spike_i),
    .start_of_train_i (start_of_train_i),
    .end_of_train_i   (end_of_train_i),
    .coeff_index_i    (coeff_index_i),
    .coeff_value_i    (coeff_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_value_o (filtered_value_o),
    .last_of_train_o  (last_of_train_o)
  );

  // Predictor state: spike history (bit k = spike k steps back) and kernel taps.
  logic [Taps-1:0]        spike_hist;
  logic signed [TapW-1:0] kernel [Taps];

  stim_item_t   stim_q [$];
  conv_result_t expected_sums [$];
  stim_item_t   dir_table [DirRows];
  stim_item_t   cur_item;

  int  fail_count;
  int  n_spikes;
  int  n_loads;
  int  n_checked;
  int  gap_left;
  int  stall_left;
  int  idle_cycles;
  bit  calm_phase;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < MaxPrinted) $display("tb: mismatch: %s", what);
    fail_count++;
  endtask

  function automatic stim_item_t make_item(input logic req, input logic spike,
                                           input logic sot, input logic eot,
                                           input logic [CoeffIdxW-1:0] idx,
                                           input logic signed [TapW-1:0] val);
    stim_item_t it;
    it = '0;
    it.req   = req;
    it.spike = spike;
    it.sot   = sot;
    it.eot   = eot;
    it.idx   = idx;
    it.val   = val;
    return it;
  endfunction

  // Update the model state for one accepted transfer and queue its result.
  task automatic convolve_item(input stim_item_t it);
    logic signed [SumW-1:0] acc;
    conv_result_t           res;
    int                     k;
    if (it.req == ReqLoad) begin
      if (int'(it.idx) < Taps) kernel[it.idx[TapIdxW-1:0]] = it.val;
    end else begin
      if (it.sot) spike_hist = '0;
      spike_hist = {spike_hist[Taps-2:0], it.spike};
      acc = '0;
      for (k = 0; k < Taps; k++) begin
        if (spike_hist[k]) acc = acc + SumW'(kernel[k]);
      end
      if (it.has_want) begin
        res.value = it.want_value;
        res.last  = it.want_last;
      end else begin
        res.value = acc;
        res.last  = it.eot;
      end
      expected_sums.push_back(res);
    end
  endtask

  // Input side: hold while stalled, insert random gaps, go flat out near the end.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        convolve_item(cur_item);
        if (cur_item.req == ReqLoad) n_loads++;
        else n_spikes++;
      end
      if (in_valid_i && in_stall_o) begin
        // hold the stalled transfer
      end else if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 9);
        in_valid_i <= 1'b0;
      end else begin
        cur_item = stim_q.pop_front();
        calm_phase = stim_q.size() < CalmItems;
        req_type_i       <= cur_item.req;
        spike_i          <= cur_item.spike;
        start_of_train_i <= cur_item.sot;
        end_of_train_i   <= cur_item.eot;
        coeff_index_i    <= cur_item.idx;
        coeff_value_i    <= cur_item.val;
        in_valid_i       <= 1'b1;
      end
    end
  end

  // Output side: compare each transfer against the oldest expected sum.
  always @(posedge clk_i) begin
    conv_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", filtered_value_o));
        end else begin
          want = expected_sums.pop_front();
          n_checked++;
          if (filtered_value_o !== want.value)
            report_mismatch($sformatf("filtered_value %0d, expected %0d",
                                      filtered_value_o, want.value));
          if (last_of_train_o !== want.last)
            report_mismatch($sformatf("last_of_train %0b, expected %0b",
                                      last_of_train_o, want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 9);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb: no transfer for %0d cycles", idle_cycles);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int               r;
    int               t;
    int               j;
    int               mode;
    int               trains;
    int               len;
    int               density;
    logic signed [TapW-1:0] tap_val;
    logic             sot;

    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    req_type_i       = ReqSpike;
    spike_i          = 1'b0;
    start_of_train_i = 1'b0;
    end_of_train_i   = 1'b0;
    coeff_index_i    = '0;
    coeff_value_i    = '0;
    out_stall_i      = 1'b0;
    spike_hist       = '0;
    for (t = 0; t < Taps; t++) kernel[t] = '0;
    fail_count  = 0;
    n_spikes    = 0;
    n_loads     = 0;
    n_checked   = 0;
    gap_left    = 0;
    stall_left  = 0;
    idle_cycles = 0;
    calm_phase  = 1'b0;

    //              req       spk   sot   eot   idx     value        has   want          last
    dir_table[0]  = '{ReqSpike, 1'b1, 1'b1, 1'b0, 6'd0,  16'sh0000, 1'b1, 22'sd0,       1'b0};
    dir_table[1]  = '{ReqSpike, 1'b1, 1'b0, 1'b1, 6'd0,  16'sh0000, 1'b1, 22'sd0,       1'b1};
    // loads ignore the spike flags
    dir_table[2]  = '{ReqLoad,  1'b1, 1'b1, 1'b1, 6'd0,  16'sh7fff, 1'b0, 22'sd0,       1'b0};
    dir_table[3]  = '{ReqLoad,  1'b0, 1'b0, 1'b0, 6'd31, 16'sh8000, 1'b0, 22'sd0,       1'b0};
    // tap numbers past the kernel are dropped
    dir_table[4]  = '{ReqLoad,  1'b0, 1'b0, 1'b0, 6'd63, 16'shffff, 1'b0, 22'sd0,       1'b0};
    dir_table[5]  = '{ReqLoad,  1'b1, 1'b0, 1'b1, 6'd32, 16'sh3039, 1'b0, 22'sd0,       1'b0};
    dir_table[6]  = '{ReqSpike, 1'b1, 1'b1, 1'b0, 6'd0,  16'sh0000, 1'b1, 22'sd32767,   1'b0};
    dir_table[7]  = '{ReqSpike, 1'b0, 1'b0, 1'b0, 6'd0,  16'sh0000, 1'b0, 22'sd0,       1'b0};
    dir_table[8]  = '{ReqLoad,  1'b0, 1'b0, 1'b0, 6'd1,  16'sh8000, 1'b0, 22'sd0,       1'b0};
    dir_table[9]  = '{ReqSpike, 1'b1, 1'b0, 1'b1, 6'd0,  16'sh0000, 1'b0, 22'sd0,       1'b0};
    dir_table[10] = '{ReqSpike, 1'b0, 1'b1, 1'b0, 6'd0,  16'sh0000, 1'b1, 22'sd0,       1'b0};
    // spike items ignore the tap fields
    dir_table[11] = '{ReqSpike, 1'b1, 1'b1, 1'b1, 6'd63, 16'shffff, 1'b1, 22'sd32767,   1'b1};
    for (r = 0; r < DirRows; r++) stim_q.push_back(dir_table[r]);

    // Random part: reload the kernel, then run a few trains over it.
    while (stim_q.size() < DirRows + RandomItems) begin
      mode = $urandom_range(0, 3);
      for (t = 0; t < Taps; t++) begin
        case (mode)
          0: tap_val = TapW'($urandom);
          1: tap_val = 16'sh7fff;
          2: tap_val = 16'sh8000;
          default: tap_val = ($urandom_range(0, 3) == 0) ? TapW'($urandom) : '0;
        endcase
        stim_q.push_back(make_item(ReqLoad, 1'($urandom), 1'($urandom), 1'($urandom),
                                   CoeffIdxW'(t), tap_val));
      end
      if ($urandom_range(0, 1) == 0)
        stim_q.push_back(make_item(ReqLoad, 1'($urandom), 1'($urandom), 1'($urandom),
                                   CoeffIdxW'($urandom_range(Taps, 63)), TapW'($urandom)));
      trains = $urandom_range(1, 4);
      for (r = 0; r < trains; r++) begin
        len     = $urandom_range(1, 48);
        density = $urandom_range(0, 4);
        for (j = 0; j < len; j++) begin
          if ($urandom_range(0, 19) == 0)
            stim_q.push_back(make_item(ReqLoad, 1'($urandom), 1'($urandom), 1'($urandom),
                                       CoeffIdxW'($urandom), TapW'($urandom)));
          sot = ((j == 0) && $urandom_range(0, 4) != 0) || ($urandom_range(0, 29) == 0);
          stim_q.push_back(make_item(ReqSpike, $urandom_range(0, 3) < density, sot,
                                     j == len - 1, CoeffIdxW'($urandom), TapW'($urandom)));
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid_i || expected_sums.size() != 0) @(posedge clk_i);
    repeat (Taps + 8) @(posedge clk_i);

    $display("tb: %0d spike and %0d tap-load transfers, %0d sums checked", n_spikes, n_loads,
             n_checked);
    $display("tb: kernels of random, full-scale and sparse taps over trains up to 48 long");
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: %0d mismatches", fail_count);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
